FILE: rtl/udp_receive_check_and_port_demux_defines.svh
// Assertion macros used by the UDP receive check and port demux top level.
`ifndef UDP_RECEIVE_CHECK_AND_PORT_DEMUX_DEFINES_SVH
`define UDP_RECEIVE_CHECK_AND_PORT_DEMUX_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define UDPRC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("udprc assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define UDPRC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("udprc assertion failed");
`else
`define UDPRC_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define UDPRC_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/udprc_pkg.sv
// Package with the types, codes and constants of the UDP receive check block.
`default_nettype none

package udprc_pkg;

  localparam int Bindings = 8;
  localparam int SlotW    = (Bindings > 1) ? $clog2(Bindings) : 1;

  localparam logic [15:0] UdpHdrLen = 16'd8;
  localparam logic [7:0]  UdpProto  = 8'd17;
  localparam logic [15:0] OnesAll   = 16'hFFFF;
  localparam logic [15:0] CountMax  = 16'hFFFF;
  localparam logic [15:0] SumAlways = 16'd6;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_BIND   = 2'd1,
    CMD_UNBIND = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_DELIVERED    = 4'd0,
    ST_SHORT        = 4'd1,
    ST_BAD_LENGTH   = 4'd2,
    ST_BAD_CHECKSUM = 4'd3,
    ST_UNBOUND_PORT = 4'd4,
    ST_BOUND        = 4'd5,
    ST_IN_USE       = 4'd6,
    ST_FULL         = 4'd7,
    ST_UNBOUND      = 4'd8,
    ST_QUERY        = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_BIND,
    OP_UNBIND,
    OP_QUERY,
    OP_SUM,
    OP_FOLD,
    OP_REPORT
  } dp_op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] port;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  slot;
    logic [15:0] src_port;
    logic [15:0] payload_len;
    logic        in_use;
  } out_word_t;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
    logic    key_dest;
  } dp_cmd_t;

  typedef struct packed {
    logic short_len;
    logic bad_len;
    logic cks_present;
    logic fold_done;
    logic fold_ok;
    logic dest_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/udprc_dp.sv
// Datapath: binding table, per-datagram header capture, checksum sum and fold, result register.
`default_nettype none

module udprc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  udprc_pkg::dp_cmd_t   dp_cmd_i,
  input  udprc_pkg::in_word_t  in_word_i,
  output udprc_pkg::dp_stat_t  dp_stat_o,
  output udprc_pkg::out_word_t out_word_o
);
  import udprc_pkg::*;

  logic [15:0]         slot_port_q [Bindings];
  logic [Bindings-1:0] slot_valid_q, slot_valid_d;
  logic                slot_we;
  logic [SlotW-1:0]    slot_waddr;

  logic [15:0] byte_count_q, byte_count_d;
  logic [31:0] running_sum_q, running_sum_d;
  logic [15:0] header_length_q, header_length_d;
  logic [15:0] dest_port_q, dest_port_d;
  logic [15:0] source_port_q, source_port_d;
  logic        cks_present_q, cks_present_d;
  logic [7:0]  hold_q, hold_d;
  logic [32:0] fold_q, fold_d;
  out_word_t   out_q, out_d;

  logic [15:0]         key;
  logic [Bindings-1:0] match;
  logic                any_hit, any_free;
  logic [SlotW-1:0]    hit_idx, free_idx;

  logic [15:0] idx;
  logic [7:0]  b;
  logic [17:0] pseudo;
  logic        summed;
  logic        add_en;
  logic [31:0] addend;

  assign key = dp_cmd_i.key_dest ? dest_port_q : in_word_i.port;

  // Parallel compare against every slot, then lowest-index priority pick.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < Bindings; i++) begin
      match[i] = slot_valid_q[i] && (slot_port_q[i] == key);
    end
    for (int i = Bindings - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SlotW'(i);
      end
      if (!slot_valid_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
    any_hit  = |match;
    any_free = ~&slot_valid_q;
  end

  assign idx    = byte_count_q;
  assign b      = in_word_i.data_byte;
  assign pseudo = 18'(in_word_i.src_addr[31:16]) + 18'(in_word_i.src_addr[15:0]) +
                  18'(in_word_i.dst_addr[31:16]) + 18'(in_word_i.dst_addr[15:0]);
  assign summed = (idx < SumAlways) || (idx < header_length_q);
  assign add_en = (idx == 16'd0) || (summed && idx[0]);
  assign addend = (idx == 16'd0) ? 32'(pseudo) : {16'd0, hold_q, b};

  always_comb begin
    slot_valid_d    = slot_valid_q;
    slot_we         = 1'b0;
    slot_waddr      = free_idx;
    byte_count_d    = byte_count_q;
    running_sum_d   = running_sum_q;
    header_length_d = header_length_q;
    dest_port_d     = dest_port_q;
    source_port_d   = source_port_q;
    cks_present_d   = cks_present_q;
    hold_d          = hold_q;
    fold_d          = fold_q;
    out_d           = out_q;

    case (dp_cmd_i.op)
      OP_BYTE: begin
        if (add_en) begin
          running_sum_d = running_sum_q + addend;
        end
        case (idx)
          16'd0:   source_port_d   = {b, 8'd0};
          16'd1:   source_port_d   = {source_port_q[15:8], b};
          16'd2:   dest_port_d     = {b, 8'd0};
          16'd3:   dest_port_d     = {dest_port_q[15:8], b};
          16'd4:   header_length_d = {b, 8'd0};
          16'd5:   header_length_d = {header_length_q[15:8], b};
          16'd6,
          16'd7:   cks_present_d   = cks_present_q || (b != 8'd0);
          default: ;
        endcase
        if (summed && !idx[0]) begin
          hold_d = b;
        end
        if (idx != CountMax) begin
          byte_count_d = idx + 16'd1;
        end
      end
      OP_BIND: begin
        out_d = '0;
        if (any_hit) begin
          out_d.status = ST_IN_USE;
          out_d.slot   = 3'(hit_idx);
        end else if (!any_free) begin
          out_d.status = ST_FULL;
        end else begin
          slot_we                = 1'b1;
          slot_valid_d[free_idx] = 1'b1;
          out_d.status           = ST_BOUND;
          out_d.slot             = 3'(free_idx);
        end
      end
      OP_UNBIND: begin
        slot_valid_d = slot_valid_q & ~match;
        out_d        = '0;
        out_d.status = ST_UNBOUND;
      end
      OP_QUERY: begin
        out_d        = '0;
        out_d.status = ST_QUERY;
        out_d.in_use = any_hit;
      end
      OP_SUM: begin
        fold_d = {1'b0, running_sum_q} + 33'(UdpProto) + 33'(header_length_q) +
                 (header_length_q[0] ? {17'd0, hold_q, 8'd0} : 33'd0);
      end
      OP_FOLD: begin
        fold_d = 33'(fold_q[15:0]) + 33'(fold_q[32:16]);
      end
      OP_REPORT: begin
        out_d        = '0;
        out_d.status = dp_cmd_i.status;
        if (dp_cmd_i.status == ST_DELIVERED) begin
          out_d.slot        = 3'(hit_idx);
          out_d.src_port    = source_port_q;
          out_d.payload_len = header_length_q - UdpHdrLen;
        end
        byte_count_d    = '0;
        running_sum_d   = '0;
        header_length_d = '0;
        dest_port_d     = '0;
        source_port_d   = '0;
        cks_present_d   = 1'b0;
        hold_d          = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q    <= '0;
      byte_count_q    <= '0;
      running_sum_q   <= '0;
      header_length_q <= '0;
      dest_port_q     <= '0;
      source_port_q   <= '0;
      cks_present_q   <= 1'b0;
      hold_q          <= '0;
    end else begin
      slot_valid_q    <= slot_valid_d;
      byte_count_q    <= byte_count_d;
      running_sum_q   <= running_sum_d;
      header_length_q <= header_length_d;
      dest_port_q     <= dest_port_d;
      source_port_q   <= source_port_d;
      cks_present_q   <= cks_present_d;
      hold_q          <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_port_q[slot_waddr] <= in_word_i.port;
    end
    fold_q <= fold_d;
    out_q  <= out_d;
  end

  assign dp_stat_o.short_len   = byte_count_q < UdpHdrLen;
  assign dp_stat_o.bad_len     = (header_length_q < UdpHdrLen) ||
                                 (header_length_q > byte_count_q);
  assign dp_stat_o.cks_present = cks_present_q;
  assign dp_stat_o.fold_done   = fold_q[32:16] == 17'd0;
  assign dp_stat_o.fold_ok     = fold_q[15:0] == OnesAll;
  assign dp_stat_o.dest_hit    = any_hit;

  assign out_word_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/udprc_ctrl.sv
// Controller: sequences commands, datagram end checks and the result handshake.
`default_nettype none

module udprc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  input  logic                in_last_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output udprc_pkg::dp_cmd_t  dp_cmd_o,
  input  udprc_pkg::dp_stat_t dp_stat_i
);
  import udprc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FOLD,
    S_LOOKUP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;
  logic   emit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d           = state_q;
    emit              = 1'b0;
    dp_cmd_o.op       = OP_NONE;
    dp_cmd_o.status   = ST_DELIVERED;
    dp_cmd_o.key_dest = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            CMD_BYTE: begin
              dp_cmd_o.op = OP_BYTE;
              if (in_last_i) begin
                state_d = S_CHECK;
              end
            end
            CMD_BIND: begin
              dp_cmd_o.op = OP_BIND;
              emit        = 1'b1;
            end
            CMD_UNBIND: begin
              dp_cmd_o.op = OP_UNBIND;
              emit        = 1'b1;
            end
            CMD_QUERY: begin
              dp_cmd_o.op = OP_QUERY;
              emit        = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (dp_stat_i.short_len || dp_stat_i.bad_len) begin
          if (out_free) begin
            dp_cmd_o.op     = OP_REPORT;
            dp_cmd_o.status = dp_stat_i.short_len ? ST_SHORT : ST_BAD_LENGTH;
            emit            = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (dp_stat_i.cks_present) begin
          dp_cmd_o.op = OP_SUM;
          state_d     = S_FOLD;
        end else begin
          state_d = S_LOOKUP;
        end
      end
      S_FOLD: begin
        if (!dp_stat_i.fold_done) begin
          dp_cmd_o.op = OP_FOLD;
        end else if (!dp_stat_i.fold_ok) begin
          if (out_free) begin
            dp_cmd_o.op     = OP_REPORT;
            dp_cmd_o.status = ST_BAD_CHECKSUM;
            emit            = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          dp_cmd_o.op     = OP_REPORT;
          dp_cmd_o.status = dp_stat_i.dest_hit ? ST_DELIVERED : ST_UNBOUND_PORT;
          emit            = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/udp_receive_check_and_port_demux.sv
// Top level of the UDP receive check and port demultiplexer.
//
// The input channel carries one word per handshake: a datagram byte, or a
// bind, unbind or query request for a port. A word is taken at a rising edge
// where in_valid_i is high and in_stall_o is low. The output channel presents
// one result word per bind, unbind and query request, and one per datagram,
// produced when the byte flagged last is taken.
// Requests and non-final bytes are taken back to back while the output is
// free; a request's result sits in the output register from the next cycle
// on. After a final byte the block makes the length checks in S_CHECK and
// forms the sum in that state when the checksum field is nonzero; a failed
// length check is reported from there. The end-around carry fold then runs
// in S_FOLD, which reports a bad checksum, and the port lookup in S_LOOKUP
// loads the result; no word is taken meanwhile.
// A new word is accepted while the previous result is being taken, but not
// while a result waits under out_stall_i, since the output register has one
// place. Reset empties the binding table, clears the datagram state and
// leaves no result pending.
`default_nettype none
`include "udp_receive_check_and_port_demux_defines.svh"

module udp_receive_check_and_port_demux (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  udprc_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output udprc_pkg::out_word_t out_word_o
);
  import udprc_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic last_taken;
  logic out_in_use;
  logic out_extra;
  logic fields_clear;

  // The controller sees only the command and end-of-datagram flag of the
  // word; all payload stays in the datapath.
  udprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_word_i.cmd),
    .in_last_i   (in_word_i.last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  udprc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dp_cmd_i   (dp_cmd),
    .in_word_i  (in_word_i),
    .dp_stat_o  (dp_stat),
    .out_word_o (out_word_o)
  );

  assign last_taken   = in_valid_i && !in_stall_o && in_word_i.cmd == CMD_BYTE &&
                        in_word_i.last;
  assign out_in_use   = out_valid_o && out_word_o.in_use;
  assign out_extra    = out_valid_o && out_word_o.status != ST_DELIVERED;
  assign fields_clear = out_word_o.src_port == 16'd0 && out_word_o.payload_len == 16'd0;

  // A final byte always starts the end-of-datagram sequence, so the input
  // must be held off on the following cycle.
  `UDPRC_ASSERT_NEXT(a_last_byte_busy, clk_i, rst_ni, last_taken, in_stall_o)

  // Only a query answer may carry the in-use flag.
  `UDPRC_ASSERT_IMPL(a_in_use_query, clk_i, rst_ni, out_in_use, out_word_o.status == ST_QUERY)

  // Source port and payload length are reported for delivered datagrams only.
  `UDPRC_ASSERT_IMPL(a_fields_delivered, clk_i, rst_ni, out_extra, fields_clear)

endmodule

`default_nettype wire

FILE: tb/sv/udp_receive_check_and_port_demux_checker.sv
// Checker that predicts and compares the result words of the UDP receive demux.
`timescale 1ns / 1ps

module udp_receive_check_and_port_demux_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  udprc_pkg::in_word_t  in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  udprc_pkg::out_word_t out_word_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  import udprc_pkg::*;

  // Shadow copy of the binding table and of the per-datagram state.
  logic [15:0] slot_port_q [Bindings];
  logic        slot_used_q [Bindings];
  logic [15:0] count_q;
  logic [15:0] hlen_q;
  logic [15:0] dport_q;
  logic [15:0] sport_q;
  logic [31:0] sum_q;
  logic        cks_seen_q;
  logic [7:0]  hold_q;

  // Result words predicted but not yet seen on the output channel, oldest first.
  out_word_t   report_fifo [$];

  function automatic int lookup_port(input logic [15:0] p);
    int i;
    lookup_port = -1;
    for (i = Bindings - 1; i >= 0; i--)
      if (slot_used_q[i] && slot_port_q[i] == p) lookup_port = i;
  endfunction

  task automatic clear_stream();
    count_q    = '0;
    hlen_q     = '0;
    dport_q    = '0;
    sport_q    = '0;
    sum_q      = '0;
    cks_seen_q = 1'b0;
    hold_q     = '0;
  endtask

  task automatic compute_report(input in_word_t w, output bit has_report,
                                output out_word_t rep);
    int          hit;
    int          open_slot;
    int          i;
    logic [15:0] idx;
    logic [63:0] total;
    logic        sum_ok;
    has_report = 1'b1;
    rep = '0;
    case (w.cmd)
      CMD_BIND: begin
        hit = lookup_port(w.port);
        open_slot = -1;
        for (i = Bindings - 1; i >= 0; i--)
          if (!slot_used_q[i]) open_slot = i;
        if (hit >= 0) begin
          rep.status = ST_IN_USE;
          rep.slot = hit[2:0];
        end else if (open_slot < 0) begin
          rep.status = ST_FULL;
        end else begin
          slot_port_q[open_slot] = w.port;
          slot_used_q[open_slot] = 1'b1;
          rep.status = ST_BOUND;
          rep.slot = open_slot[2:0];
        end
      end
      CMD_UNBIND: begin
        for (i = 0; i < Bindings; i++)
          if (slot_used_q[i] && slot_port_q[i] == w.port) slot_used_q[i] = 1'b0;
        rep.status = ST_UNBOUND;
      end
      CMD_QUERY: begin
        rep.status = ST_QUERY;
        rep.in_use = (lookup_port(w.port) >= 0);
      end
      CMD_BYTE: begin
        idx = count_q;
        // The pseudo-header addresses are taken from the first byte only.
        if (idx == 16'd0)
          sum_q = sum_q + w.src_addr[31:16] + w.src_addr[15:0]
                        + w.dst_addr[31:16] + w.dst_addr[15:0];
        case (idx)
          16'd0: sport_q = {w.data_byte, 8'h00};
          16'd1: sport_q = sport_q | {8'h00, w.data_byte};
          16'd2: dport_q = {w.data_byte, 8'h00};
          16'd3: dport_q = dport_q | {8'h00, w.data_byte};
          16'd4: hlen_q = {w.data_byte, 8'h00};
          16'd5: hlen_q = hlen_q | {8'h00, w.data_byte};
          16'd6, 16'd7: if (w.data_byte != 8'h00) cks_seen_q = 1'b1;
          default: ;
        endcase
        if (idx < SumAlways || idx < hlen_q) begin
          if (!idx[0]) hold_q = w.data_byte;
          else sum_q = sum_q + {hold_q, w.data_byte};
        end
        if (count_q != CountMax) count_q = count_q + 16'd1;
        if (!w.last) begin
          has_report = 1'b0;
        end else begin
          if (count_q < UdpHdrLen) begin
            rep.status = ST_SHORT;
          end else if (hlen_q < UdpHdrLen || hlen_q > count_q) begin
            rep.status = ST_BAD_LENGTH;
          end else begin
            sum_ok = 1'b1;
            if (cks_seen_q) begin
              total = sum_q + UdpProto + hlen_q;
              // An odd length leaves its last byte waiting, padded low.
              if (hlen_q[0]) total = total + {hold_q, 8'h00};
              while (total[63:16] != 0) total = total[15:0] + total[63:16];
              sum_ok = (total[15:0] == OnesAll);
            end
            hit = lookup_port(dport_q);
            if (!sum_ok) begin
              rep.status = ST_BAD_CHECKSUM;
            end else if (hit < 0) begin
              rep.status = ST_UNBOUND_PORT;
            end else begin
              rep.status = ST_DELIVERED;
              rep.slot = hit[2:0];
              rep.src_port = sport_q;
              rep.payload_len = hlen_q - UdpHdrLen;
            end
          end
          clear_stream();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t oldest;
    out_word_t report;
    bit        has_report;
    int        i;
    if (!rst_ni) begin
      for (i = 0; i < Bindings; i++) begin
        slot_port_q[i] = '0;
        slot_used_q[i] = 1'b0;
      end
      clear_stream();
      report_fifo.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // A result taken now was caused by a word taken at an earlier edge.
      if (out_valid_i && !out_stall_i) begin
        if (report_fifo.size() == 0) begin
          $display("%0t: unexpected result word, status %0d slot %0d src_port %0h",
                   $time, out_word_i.status, out_word_i.slot, out_word_i.src_port);
          fail_count_o++;
        end else begin
          oldest = report_fifo.pop_front();
          check_field("status", 16'(oldest.status), 16'(out_word_i.status));
          check_field("slot", 16'(oldest.slot), 16'(out_word_i.slot));
          check_field("src_port", oldest.src_port, out_word_i.src_port);
          check_field("payload_len", oldest.payload_len, out_word_i.payload_len);
          check_field("in_use", 16'(oldest.in_use), 16'(out_word_i.in_use));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        compute_report(in_word_i, has_report, report);
        if (has_report) report_fifo.push_back(report);
      end
      pending_o = report_fifo.size();
    end
  end

endmodule

FILE: tb/sv/udp_receive_check_and_port_demux_test.sv
// Test top that drives the UDP receive demux with words and reports the verdict.
`timescale 1ns / 1ps

module udp_receive_check_and_port_demux_test;
  import udprc_pkg::*;

  // No new datagram or request is started once this many words have been
  // taken, directed part included.
  localparam int unsigned WordBudget  = 1150;
  // The slowest legal run stays far below this many cycles.
  localparam int unsigned CycleLimit  = 1000000;
  // Extra cycles waited once no result is pending.
  localparam int unsigned DrainCycles = 16;

  // How the checksum field of a generated datagram is filled in.
  typedef enum int {
    CKS_ZERO,
    CKS_GOOD,
    CKS_BAD
  } cks_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_word_o;

  int unsigned failures;
  int unsigned pending;
  int unsigned words_sent;

  // Percent of words preceded by an idle gap, and percent of cycles that
  // start a stall run on the result side. Both change between phases.
  int          idle_pct;
  int          stall_pct;

  udp_receive_check_and_port_demux dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // The checker watches both channels from the outside, predicts every result
  // word and compares; this module only makes stimulus and gives the verdict.
  udp_receive_check_and_port_demux_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .fail_count_o (failures),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap lengths are mostly short with a rare long one; pct of zero turns
  // idling off completely so that back-to-back stretches occur as well.
  function automatic int pick_gap(input int pct);
    int r;
    if ($urandom_range(99, 0) >= pct) return 0;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 93) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Fields a word does not use still carry random bits, so every input bit
  // toggles no matter which command is sent.
  function automatic in_word_t random_word();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(in_word_t)-1:0];
  endfunction

  // Most ports come from a small pool, so that binds collide, the table
  // fills up and datagrams find their port; the rest are fully random.
  function automatic logic [15:0] pick_port();
    if ($urandom_range(4, 0) == 0) return 16'($urandom);
    case ($urandom_range(11, 0))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h0007;
      3:       return 16'h0035;
      4:       return 16'h0050;
      5:       return 16'h01BB;
      6:       return 16'h1000;
      7:       return 16'h8000;
      8:       return 16'hAAAA;
      9:       return 16'h5555;
      10:      return 16'hFFFE;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Presents one word and returns at the edge where it was taken. Valid is
  // only lowered when an idle gap comes before the next word, so a word that
  // follows back-to-back keeps valid high without a second assignment.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap(idle_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_word_i <= random_word();
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_command(input cmd_e c, input logic [15:0] p);
    in_word_t w;
    w = random_word();
    w.cmd = c;
    w.port = p;
    send_word(w);
  endtask

  task automatic send_random_command();
    int r;
    r = $urandom_range(99, 0);
    send_command((r < 45) ? CMD_BIND : (r < 70) ? CMD_UNBIND : CMD_QUERY, pick_port());
  endtask

  // Builds a datagram of nbytes bytes: the eight header bytes come first (cut
  // short when nbytes is below eight), then random payload. A good checksum
  // covers the pseudo-header and the first hl bytes, the odd one padded low.
  // With mix_pct above zero, requests are slipped in between the bytes.
  task automatic send_datagram(input logic [31:0] sa, input logic [31:0] da,
                               input logic [15:0] sp, input logic [15:0] dp,
                               input logic [15:0] hl, input int nbytes,
                               input cks_kind_e ck, input int mix_pct);
    logic [7:0]  dg [$];
    logic [63:0] hdr;
    logic [63:0] s;
    logic [15:0] cks;
    in_word_t    w;
    int          i;
    hdr = {sp, dp, hl, 16'h0000};
    for (i = 0; i < nbytes; i++)
      dg.push_back((i < 8) ? hdr[63 - 8 * i -: 8] : 8'($urandom));
    if (ck != CKS_ZERO && nbytes >= 8) begin
      s = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + UdpProto + hl;
      for (i = 0; i < hl && i < nbytes; i += 2)
        s = s + {dg[i], (i + 1 < hl && i + 1 < nbytes) ? dg[i + 1] : 8'h00};
      while (s[63:16] != 0) s = s[15:0] + s[63:16];
      cks = ~s[15:0];
      // A computed zero is sent as all ones, since zero means no checksum.
      if (cks == 16'h0000) cks = OnesAll;
      if (ck == CKS_BAD) cks = cks ^ 16'($urandom_range(65535, 1));
      dg[6] = cks[15:8];
      dg[7] = cks[7:0];
    end
    for (i = 0; i < nbytes; i++) begin
      if (i > 0 && $urandom_range(99, 0) < mix_pct) send_random_command();
      w = random_word();
      w.cmd = CMD_BYTE;
      w.data_byte = dg[i];
      w.last = (i == nbytes - 1);
      if (i == 0) begin
        w.src_addr = sa;
        w.dst_addr = da;
      end
      send_word(w);
    end
  endtask

  // Result side: stall runs of random length, each ended by lowering the stall so
  // that a waiting result can be taken.
  initial begin : result_stall
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      n = pick_gap(stall_pct);
      out_stall_i <= (n > 0);
      if (n > 0) begin
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Ends the run as failed if it is still going at the cycle limit.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int          k;
    int          r;
    int          plen;
    int          nb;
    logic [15:0] hl;
    cks_kind_e   ck;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    words_sent  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The table starts empty, then fills with the port
    // extremes and a run of small ports until a bind finds no free slot.
    idle_pct  = 30;
    stall_pct = 30;
    send_command(CMD_QUERY, 16'h0000);
    send_command(CMD_BIND, 16'h0000);
    send_command(CMD_BIND, 16'hFFFF);
    send_command(CMD_BIND, 16'h0000);
    for (k = 1; k <= 6; k++) send_command(CMD_BIND, 16'(k));
    send_command(CMD_BIND, 16'h0007);
    send_command(CMD_QUERY, 16'hFFFF);
    // Unbind frees a middle slot; a second unbind of the same port still
    // answers, and the next bind takes the freed slot.
    send_command(CMD_UNBIND, 16'h0003);
    send_command(CMD_UNBIND, 16'h0003);
    send_command(CMD_BIND, 16'h1234);

    // Datagram cases: too few bytes, a length field below the header size,
    // a length field past the received count, no checksum, a good checksum
    // over an odd length with all-ones addresses, trailing bytes beyond the
    // length, a corrupted checksum, an unbound port, and requests slipped
    // into the middle of a datagram.
    send_datagram(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'h0000, 16'd8, 5,
                  CKS_GOOD, 0);
    send_datagram(32'h0A00_0001, 32'h0A00_0002, 16'h1111, 16'h0000, 16'd4, 12,
                  CKS_ZERO, 0);
    send_datagram(32'h0A00_0001, 32'h0A00_0002, 16'h2222, 16'h0000, 16'd20, 12,
                  CKS_GOOD, 0);
    send_datagram(32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'd8, 8,
                  CKS_ZERO, 0);
    send_datagram(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'd13, 13,
                  CKS_GOOD, 0);
    send_datagram($urandom, $urandom, 16'h4D2C, 16'h1234, 16'd16, 20, CKS_GOOD, 0);
    send_datagram($urandom, $urandom, 16'h0101, 16'h0001, 16'd10, 10, CKS_BAD, 0);
    send_datagram($urandom, $urandom, 16'h0202, 16'h4321, 16'd8, 8, CKS_GOOD, 0);
    send_datagram($urandom, $urandom, 16'h0303, 16'h0002, 16'd12, 12, CKS_GOOD, 50);

    // Random part: mostly well-formed datagrams with random content and a
    // correct checksum or none, mixed with requests, and a share of broken
    // datagrams. Idle rates change now and then so every phase of the block
    // meets gaps and stalls, and some stretches run without any.
    while (words_sent < WordBudget) begin
      if ($urandom_range(99, 0) < 4) begin
        idle_pct  = 30 * $urandom_range(2, 0);
        stall_pct = 30 * $urandom_range(2, 0);
      end
      r = $urandom_range(99, 0);
      if (r < 25) begin
        send_random_command();
      end else begin
        plen = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 0) : $urandom_range(20, 0);
        hl = 16'(8 + plen);
        nb = 8 + plen + (($urandom_range(3, 0) == 0) ? $urandom_range(4, 1) : 0);
        k = $urandom_range(99, 0);
        ck = (k < 35) ? CKS_ZERO : (k < 90) ? CKS_GOOD : CKS_BAD;
        if (r >= 80) begin
          case ($urandom_range(3, 0))
            0:       nb = $urandom_range(7, 1);
            1:       hl = 16'($urandom_range(7, 0));
            2:       nb = $urandom_range(hl - 1, 1);
            default: hl = 16'($urandom);
          endcase
        end
        send_datagram($urandom, $urandom, 16'($urandom), pick_port(), hl, nb, ck, 3);
      end
    end
    in_valid_i <= 1'b0;

    // Let the checker see the last word taken, drain every expected result,
    // then give the block time to show anything it should not.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: udp_receive_check_and_port_demux.f
+incdir+rtl
rtl/udprc_pkg.sv
rtl/udprc_dp.sv
rtl/udprc_ctrl.sv
rtl/udp_receive_check_and_port_demux.sv
tb/sv/udp_receive_check_and_port_demux_checker.sv
tb/sv/udp_receive_check_and_port_demux_test.sv
